>>> rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared constants and a helper for the circle contact core.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

    localparam int COORD_WIDTH_DEF      = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // extra fraction bits kept in the square root result
    function automatic int ext_bits(input int w);
        return (w <= 24) ? 8 : 32 - w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ccc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ccc_sqrt_cell
// One restoring square root step: decides root bit K and passes on.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_sqrt_cell #(
    parameter int ROOT_W = 31,
    parameter int K      = 30,
    parameter int SIDE_W = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [2*ROOT_W:0]     in_rem,
    input  wire logic [ROOT_W-1:0]     in_root,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output logic [2*ROOT_W:0]          out_rem,
    output logic [ROOT_W-1:0]          out_root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int REM_W = 2 * ROOT_W + 1;

    logic [REM_W-1:0] trial;
    logic             take;
    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;

    // (2*root + 2^K) * 2^K
    assign trial = (REM_W'(in_root) << (K + 1)) | (REM_W'(1) << (2 * K));
    assign take  = (in_rem >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= take ? (in_rem - trial) : in_rem;
            root_reg <= take ? (in_root | (ROOT_W'(1) << K)) : in_root;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

>>> rtl/ccc_div_cell.sv
// ----------------------------------------------------------------------------
// ccc_div_cell
// One restoring divide step for both normal lanes: decides quotient bit K.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_div_cell #(
    parameter int DIV_W  = 46,
    parameter int LEN_W  = 31,
    parameter int Q_W    = 15,
    parameter int K      = 14,
    parameter int SIDE_W = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [DIV_W-1:0]   in_rem_x,
    input  wire logic [DIV_W-1:0]   in_rem_y,
    input  wire logic [Q_W-1:0]     in_q_x,
    input  wire logic [Q_W-1:0]     in_q_y,
    input  wire logic [LEN_W-1:0]   in_len,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output logic [DIV_W-1:0]        out_rem_x,
    output logic [DIV_W-1:0]        out_rem_y,
    output logic [Q_W-1:0]          out_q_x,
    output logic [Q_W-1:0]          out_q_y,
    output logic [LEN_W-1:0]        out_len,
    output logic [SIDE_W-1:0]       out_side
);

    logic [DIV_W-1:0]  trial;
    logic              take_x;
    logic              take_y;
    logic              valid_reg;
    logic [DIV_W-1:0]  rem_x_reg;
    logic [DIV_W-1:0]  rem_y_reg;
    logic [Q_W-1:0]    q_x_reg;
    logic [Q_W-1:0]    q_y_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SIDE_W-1:0] side_reg;

    assign trial  = DIV_W'(in_len) << K;
    assign take_x = (in_rem_x >= trial);
    assign take_y = (in_rem_y >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_x_reg <= take_x ? (in_rem_x - trial) : in_rem_x;
            rem_y_reg <= take_y ? (in_rem_y - trial) : in_rem_y;
            q_x_reg   <= take_x ? (in_q_x | (Q_W'(1) << K)) : in_q_x;
            q_y_reg   <= take_y ? (in_q_y | (Q_W'(1) << K)) : in_q_y;
            len_reg   <= in_len;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_q_x   = q_x_reg;
    assign out_q_y   = q_y_reg;
    assign out_len   = len_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

>>> rtl/circle_circle_contact_core.sv
// ----------------------------------------------------------------------------
// circle_circle_contact_core
// Narrow-phase contact between two circles: normal, depth, contact point.
// ----------------------------------------------------------------------------
// Pipeline: stages 1 to 3, the square root cell row, stage 4, the divider cell
//   row, stage 5 and the output register (E = 8 up to 24 bit coordinates).
// Throughput: one beat per cycle while not stalled; set by the square root
//   cell row (one root bit per cell) and the divider cell row (one quotient bit per cell).
// The output holds a skid entry; once it fills the pipe stalls until a beat leaves.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none

module circle_circle_contact_core #(
    parameter int COORD_WIDTH      = ccc_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = ccc_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [COORD_WIDTH-1:0]        s_center_a_x,
    input  wire logic [COORD_WIDTH-1:0]        s_center_a_y,
    input  wire logic [COORD_WIDTH-1:0]        s_center_b_x,
    input  wire logic [COORD_WIDTH-1:0]        s_center_b_y,
    input  wire logic [COORD_WIDTH-3:0]        s_radius_a,
    input  wire logic [COORD_WIDTH-3:0]        s_radius_b,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic [NORMAL_FRAC_BITS+1:0]        m_normal_x,
    output logic [NORMAL_FRAC_BITS+1:0]        m_normal_y,
    output logic [COORD_WIDTH-2:0]             m_depth,
    output logic [COORD_WIDTH-1:0]             m_contact_x,
    output logic [COORD_WIDTH-1:0]             m_contact_y
);
    import ccc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int E     = ext_bits(COORD_WIDTH);
    localparam int SQ    = W - 1 + E;
    localparam int RAD_W = 2 * SQ + 1;
    localparam int DIV_W = W + F + E;
    localparam int Q_W   = F + 1;
    localparam int N_W   = F + 2;
    localparam int P_W   = F + W - 1;
    localparam int SS_W  = 2 * W + (W - 2) + (W - 1) + 2 * (W - 1) + 4;
    localparam int DS_W  = 2 * W + (W - 2) + (W - 1) + 4;
    localparam int RES_W = 1 + 2 * N_W + (W - 1) + 2 * W;

    logic en;

    // ---------------- stage 1: differences and magnitudes ----------------
    logic [W:0]   dxw, dyw, magx, magy;
    logic         v1_reg, sx1_reg, sy1_reg, far1_reg;
    logic [W-1:0] ax1_reg, ay1_reg;
    logic [W-3:0] ra1_reg;
    logic [W-2:0] sum1_reg, adx1_reg, ady1_reg;

    assign dxw  = {s_center_b_x[W-1], s_center_b_x} - {s_center_a_x[W-1], s_center_a_x};
    assign dyw  = {s_center_b_y[W-1], s_center_b_y} - {s_center_a_y[W-1], s_center_a_y};
    assign magx = dxw[W] ? (~dxw + 1'b1) : dxw;
    assign magy = dyw[W] ? (~dyw + 1'b1) : dyw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg  <= s_center_a_x;
            ay1_reg  <= s_center_a_y;
            ra1_reg  <= s_radius_a;
            sum1_reg <= {1'b0, s_radius_a} + {1'b0, s_radius_b};
            adx1_reg <= magx[W-2:0];
            ady1_reg <= magy[W-2:0];
            sx1_reg  <= dxw[W];
            sy1_reg  <= dyw[W];
            far1_reg <= (|magx[W:W-1]) | (|magy[W:W-1]);
        end
    end

    // ---------------- stage 2: squares ----------------
    logic           v2_reg, sx2_reg, sy2_reg, far2_reg;
    logic [W-1:0]   ax2_reg, ay2_reg;
    logic [W-3:0]   ra2_reg;
    logic [W-2:0]   sum2_reg, adx2_reg, ady2_reg;
    logic [2*W-3:0] sqx2_reg, sqy2_reg, sumsq2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx2_reg   <= adx1_reg * adx1_reg;
            sqy2_reg   <= ady1_reg * ady1_reg;
            sumsq2_reg <= sum1_reg * sum1_reg;
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            ra2_reg    <= ra1_reg;
            sum2_reg   <= sum1_reg;
            adx2_reg   <= adx1_reg;
            ady2_reg   <= ady1_reg;
            sx2_reg    <= sx1_reg;
            sy2_reg    <= sy1_reg;
            far2_reg   <= far1_reg;
        end
    end

    // ---------------- stage 3: overlap test, radicand ----------------
    logic [2*W-2:0]   d2;
    logic             v3_reg;
    logic [RAD_W-1:0] rad3_reg;
    logic [SS_W-1:0]  side3_reg;

    assign d2 = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad3_reg  <= RAD_W'(d2[2*W-3:0]) << (2 * E);
            side3_reg <= {ax2_reg, ay2_reg, ra2_reg, sum2_reg, adx2_reg, ady2_reg,
                          sx2_reg, sy2_reg,
                          (!far2_reg && ({1'b0, sumsq2_reg} > d2)),
                          (d2 == '0)};
        end
    end

    // ---------------- square root cell row ----------------
    logic             sq_v    [0:SQ];
    logic [RAD_W-1:0] sq_rem  [0:SQ];
    logic [SQ-1:0]    sq_root [0:SQ];
    logic [SS_W-1:0]  sq_side [0:SQ];

    assign sq_v[0]    = v3_reg;
    assign sq_rem[0]  = rad3_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = side3_reg;

    for (genvar i = 0; i < SQ; i++) begin : g_sqrt
        ccc_sqrt_cell #(
            .ROOT_W (SQ),
            .K      (SQ - 1 - i),
            .SIDE_W (SS_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ---------------- stage 4: depth and dividends ----------------
    logic [W-1:0] ax3, ay3;
    logic [W-3:0] ra3;
    logic [W-2:0] sum3, adx3, ady3, dist3;
    logic         sx3, sy3, hit3, zero3;
    logic [SQ-1:0] len3;

    assign len3 = sq_root[SQ];
    assign {ax3, ay3, ra3, sum3, adx3, ady3, sx3, sy3, hit3, zero3} = sq_side[SQ];
    assign dist3 = len3[SQ-1:E];

    logic             v4_reg;
    logic [DIV_W-1:0] remx4_reg, remy4_reg;
    logic [SQ-1:0]    len4_reg;
    logic [DS_W-1:0]  side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_v[SQ];
        end
    end

    // dividend carries half the divisor so the quotient comes out rounded
    always_ff @(posedge aclk) begin
        if (en) begin
            remx4_reg <= (DIV_W'(adx3) << (F + E)) + DIV_W'(len3 >> 1);
            remy4_reg <= (DIV_W'(ady3) << (F + E)) + DIV_W'(len3 >> 1);
            len4_reg  <= len3;
            side4_reg <= {ax3, ay3, ra3, sum3 - dist3, sx3, sy3, hit3, zero3};
        end
    end

    // ---------------- divider cell row ----------------
    logic             dv_v    [0:Q_W];
    logic [DIV_W-1:0] dv_rx   [0:Q_W];
    logic [DIV_W-1:0] dv_ry   [0:Q_W];
    logic [Q_W-1:0]   dv_qx   [0:Q_W];
    logic [Q_W-1:0]   dv_qy   [0:Q_W];
    logic [SQ-1:0]    dv_len  [0:Q_W];
    logic [DS_W-1:0]  dv_side [0:Q_W];

    assign dv_v[0]    = v4_reg;
    assign dv_rx[0]   = remx4_reg;
    assign dv_ry[0]   = remy4_reg;
    assign dv_qx[0]   = '0;
    assign dv_qy[0]   = '0;
    assign dv_len[0]  = len4_reg;
    assign dv_side[0] = side4_reg;

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        ccc_div_cell #(
            .DIV_W  (DIV_W),
            .LEN_W  (SQ),
            .Q_W    (Q_W),
            .K      (F - i),
            .SIDE_W (DS_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_rem_x  (dv_rx[i]),
            .in_rem_y  (dv_ry[i]),
            .in_q_x    (dv_qx[i]),
            .in_q_y    (dv_qy[i]),
            .in_len    (dv_len[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_v[i+1]),
            .out_rem_x (dv_rx[i+1]),
            .out_rem_y (dv_ry[i+1]),
            .out_q_x   (dv_qx[i+1]),
            .out_q_y   (dv_qy[i+1]),
            .out_len   (dv_len[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    // ---------------- stage 5: clamp and scale by radius ----------------
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << F;

    logic [W-1:0] ax5, ay5;
    logic [W-3:0] ra5;
    logic [W-2:0] depth5;
    logic         sx5, sy5, hit5, zero5;
    logic [Q_W-1:0] qx5, qy5;

    assign {ax5, ay5, ra5, depth5, sx5, sy5, hit5, zero5} = dv_side[Q_W];
    assign qx5 = (dv_qx[Q_W] > ONE_Q) ? ONE_Q : dv_qx[Q_W];
    assign qy5 = (dv_qy[Q_W] > ONE_Q) ? ONE_Q : dv_qy[Q_W];

    logic           v6_reg, sx6_reg, sy6_reg, hit6_reg, zero6_reg;
    logic [W-1:0]   ax6_reg, ay6_reg;
    logic [W-3:0]   ra6_reg;
    logic [W-2:0]   depth6_reg;
    logic [Q_W-1:0] qx6_reg, qy6_reg;
    logic [P_W-1:0] px6_reg, py6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= dv_v[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px6_reg    <= qx5 * ra5;
            py6_reg    <= qy5 * ra5;
            qx6_reg    <= qx5;
            qy6_reg    <= qy5;
            ax6_reg    <= ax5;
            ay6_reg    <= ay5;
            ra6_reg    <= ra5;
            depth6_reg <= depth5;
            sx6_reg    <= sx5;
            sy6_reg    <= sy5;
            hit6_reg   <= hit5;
            zero6_reg  <= zero5;
        end
    end

    // ---------------- final combine ----------------
    logic [P_W:0]   rndx, rndy;
    logic [W+1:0]   cxw, cyw;
    logic [W-1:0]   cx_sat, cy_sat, cx_fin, cy_fin;
    logic [N_W-1:0] nx_fin, ny_fin;
    logic [W-2:0]   depth_fin;
    logic [RES_W-1:0] res;

    assign rndx = {1'b0, px6_reg} + ((P_W + 1)'(1) << (F - 1));
    assign rndy = {1'b0, py6_reg} + ((P_W + 1)'(1) << (F - 1));
    assign cxw  = sx6_reg ? ({{2{ax6_reg[W-1]}}, ax6_reg} - {2'b00, rndx[P_W:F]})
                          : ({{2{ax6_reg[W-1]}}, ax6_reg} + {2'b00, rndx[P_W:F]});
    assign cyw  = sy6_reg ? ({{2{ay6_reg[W-1]}}, ay6_reg} - {2'b00, rndy[P_W:F]})
                          : ({{2{ay6_reg[W-1]}}, ay6_reg} + {2'b00, rndy[P_W:F]});

    always_comb begin
        if (cxw[W+1:W-1] == 3'b000 || cxw[W+1:W-1] == 3'b111) begin
            cx_sat = cxw[W-1:0];
        end else begin
            cx_sat = cxw[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if (cyw[W+1:W-1] == 3'b000 || cyw[W+1:W-1] == 3'b111) begin
            cy_sat = cyw[W-1:0];
        end else begin
            cy_sat = cyw[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end

        if (!hit6_reg) begin
            nx_fin    = '0;
            ny_fin    = '0;
            depth_fin = '0;
            cx_fin    = '0;
            cy_fin    = '0;
        end else if (zero6_reg) begin
            // coincident centers: fixed normal along +x
            nx_fin    = N_W'(ONE_Q);
            ny_fin    = '0;
            depth_fin = {1'b0, ra6_reg};
            cx_fin    = ax6_reg;
            cy_fin    = ay6_reg;
        end else begin
            nx_fin    = sx6_reg ? (~N_W'(qx6_reg) + 1'b1) : N_W'(qx6_reg);
            ny_fin    = sy6_reg ? (~N_W'(qy6_reg) + 1'b1) : N_W'(qy6_reg);
            depth_fin = depth6_reg;
            cx_fin    = cx_sat;
            cy_fin    = cy_sat;
        end
    end

    assign res = {hit6_reg, nx_fin, ny_fin, depth_fin, cx_fin, cy_fin};

    // ---------------- output register with skid entry ----------------
    logic             out_valid_reg, skid_valid_reg;
    logic [RES_W-1:0] out_data_reg, skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (v6_reg) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (v6_reg) begin
            if (out_valid_reg && !m_ready) begin
                skid_data_reg <= res;
            end else begin
                out_data_reg <= res;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign {m_hit, m_normal_x, m_normal_y, m_depth, m_contact_x, m_contact_y} = out_data_reg;

endmodule

`default_nettype wire
